[hdl/ped_pkg.sv]
// ----------------------------------------------------------------------------
// ped_pkg: shared definitions for the plate edge point detector
// Pixel width, register indexes, register reset values and the default
// depth limit of the lateral offset.
// ----------------------------------------------------------------------------
package ped_pkg;

   localparam int PIX_W              = 8;
   localparam int CSR_DATA_W         = 12;
   localparam int CSR_ADDR_W         = 2;
   localparam int DEFAULT_MAX_OFFSET = 32;

   // register indexes on the csr port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE    = 2'd0,
      CSR_OFFSET  = 2'd1,
      CSR_MIN_DIF = 2'd2,
      CSR_RATIO   = 2'd3
   } csr_index_type;

   // output modes
   localparam logic MODE_SCORE  = 1'b0;
   localparam logic MODE_BINARY = 1'b1;

   localparam logic [5:0]  RST_OFFSET  = 6'd4;
   localparam logic [7:0]  RST_MIN_DIF = 8'd20;
   localparam logic [11:0] RST_RATIO   = 12'd128;

endpackage

[hdl/ped_line_mem.sv]
// ----------------------------------------------------------------------------
// ped_line_mem: row pixel store
// Circular pixel memory, one write and two registered reads per cycle.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module ped_line_mem #(
   parameter int DEPTH = 2 * ped_pkg::DEFAULT_MAX_OFFSET,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [ped_pkg::PIX_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr_a,
   input  logic [AW-1:0]             rd_addr_b,
   output logic [ped_pkg::PIX_W-1:0] rd_data_a,
   output logic [ped_pkg::PIX_W-1:0] rd_data_b
);

   logic [ped_pkg::PIX_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

[hdl/plate_edge_point_detector.sv]
// ----------------------------------------------------------------------------
// plate_edge_point_detector: lateral contrast detector for plate edges
// Pixel stream in, one score per center pixel out, three-stage pipeline
// around a circular row memory.
// ----------------------------------------------------------------------------
// Use:
//   req_*  : pixel words in row order; tuser flags the first pixel of a row,
//            tlast the last one.
//   rsp_*  : one word per center pixel once 2*offset pixels of the row have
//            been seen; tlast marks the result made by the row's last pixel.
//   csr_*  : register writes (mode, offset, min_dif, lateral_ratio), made
//            while the stream is idle.
//   Timing: three registers (memory read, contrast stage, score stage) lie
//   between a pixel and its result; the memory read register loads at the
//   edge that accepts the pixel.
//   Throughput: one pixel per clock until a receiver stall fills the pipeline;
//   the single write port and two read ports of the row memory serve each pixel.
//   A pixel that makes no result only writes the memory and moves the row
//   count and write pointer. When the receiver stalls, the pipeline fills up
//   and req_tready falls once all three stages hold a word; nothing is dropped.
//   Reset clears row count, write pointer and valids, and resets registers. The memory
//   needs no clearing: the row count keeps unwritten entries from being used.
// ----------------------------------------------------------------------------
module plate_edge_point_detector #(
   parameter int MAX_OFFSET = ped_pkg::DEFAULT_MAX_OFFSET
) (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] pixel
   input  logic                          req_tuser,   // [0] first_in_row
   input  logic                          req_tlast,   // last_in_row
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] score
   output logic                          rsp_tlast,   // row_end
   // register writes
   input  logic                          csr_we,
   input  logic [ped_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ped_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH  = 2 * MAX_OFFSET;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int TW     = (FILL_W > 7) ? FILL_W : 7;
   localparam int PW     = ped_pkg::PIX_W;

   // ---------------------------------------------------------------- registers
   logic        mode_ff;
   logic [5:0]  offset_ff;
   logic [7:0]  min_dif_ff;
   logic [11:0] ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ped_pkg::MODE_SCORE;
         offset_ff  <= ped_pkg::RST_OFFSET;
         min_dif_ff <= ped_pkg::RST_MIN_DIF;
         ratio_ff   <= ped_pkg::RST_RATIO;
      end else if (csr_we) begin
         unique case (ped_pkg::csr_index_type'(csr_addr))
            ped_pkg::CSR_MODE:    mode_ff    <= csr_wdata[0];
            ped_pkg::CSR_OFFSET:  offset_ff  <= csr_wdata[5:0];
            ped_pkg::CSR_MIN_DIF: min_dif_ff <= csr_wdata[7:0];
            ped_pkg::CSR_RATIO:   ratio_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- handshake chain
   logic s1_v_ff, s2_v_ff, rsp_v_ff;
   logic out_rdy, s2_rdy, s1_rdy, accept;

   // a stage advances when it is empty or the stage after it advances
   assign out_rdy    = !rsp_v_ff || rsp_tready;
   assign s2_rdy     = !s2_v_ff || out_rdy;
   assign s1_rdy     = !s1_v_ff || s2_rdy;
   assign req_tready = s1_rdy;
   assign accept     = req_tvalid && req_tready;

   // ---------------------------------------------------------- offset, addresses
   logic [TW-1:0] off_ext, eff_off, two_off;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_base;
   logic [AW-1:0] wp_ff, wp_in, addr_l, addr_c;
   logic fire;

   // clamp the offset to 1..MAX_OFFSET
   always_comb begin
      off_ext = TW'(offset_ff);
      if (off_ext == '0) begin
         eff_off = TW'(1);
      end else if (off_ext > TW'(MAX_OFFSET)) begin
         eff_off = TW'(MAX_OFFSET);
      end else begin
         eff_off = off_ext;
      end
      two_off = eff_off << 1;
   end

   // step back through the ring: distance d from the write pointer
   function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] wp,
                                               input logic [TW-1:0] d);
      logic [AW+TW:0] w, dd;
      begin
         w  = (AW+TW+1)'(wp);
         dd = (AW+TW+1)'(d);
         if (w >= dd) begin
            ring_back = AW'(w - dd);
         end else begin
            ring_back = AW'(w + (AW+TW+1)'(DEPTH) - dd);
         end
      end
   endfunction

   assign addr_l = ring_back(wp_ff, two_off);
   assign addr_c = ring_back(wp_ff, eff_off);

   // row count: a first-of-row pixel starts from zero, a last-of-row one ends it
   always_comb begin
      fill_base = req_tuser ? '0 : fill_ff;
      fire      = TW'(fill_base) >= two_off;
      if (req_tlast) begin
         fill_in = '0;
      end else if (fill_base < FILL_W'(DEPTH)) begin
         fill_in = fill_base + FILL_W'(1);
      end else begin
         fill_in = fill_base;
      end
      if (wp_ff == AW'(DEPTH - 1)) begin
         wp_in = '0;
      end else begin
         wp_in = wp_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         wp_ff   <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
         wp_ff   <= wp_in;
      end
   end

   // ---------------------------------------------------------- stage 1: memory
   logic [PW-1:0] l_rd, c_rd;
   logic [PW-1:0] s1_r_ff;
   logic          s1_last_ff;

   ped_line_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_line_mem (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wp_ff),
      .wr_data   (req_tdata[PW-1:0]),
      .rd_en     (accept),
      .rd_addr_a (addr_l),
      .rd_addr_b (addr_c),
      .rd_data_a (l_rd),
      .rd_data_b (c_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= accept && fire;
      end
   end

   // hold the right neighbour beside the memory read data
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_r_ff    <= req_tdata[PW-1:0];
         s1_last_ff <= req_tlast;
      end
   end

   // ---------------------------------------------------------- stage 2: contrast
   logic [PW-1:0] dl, dr, lo_in, lat_in;
   logic [PW-1:0] s2_lo_ff, s2_lat_ff;
   logic          s2_last_ff;

   always_comb begin
      dl     = (l_rd > c_rd) ? l_rd - c_rd : '0;
      dr     = (s1_r_ff > c_rd) ? s1_r_ff - c_rd : '0;
      lo_in  = (dl < dr) ? dl : dr;
      lat_in = (l_rd > s1_r_ff) ? l_rd - s1_r_ff : s1_r_ff - l_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_lo_ff   <= lo_in;
         s2_lat_ff  <= lat_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------- stage 3: score
   logic [19:0]   prod;
   logic [11:0]   limit;
   logic [PW-1:0] score_in;
   logic [PW-1:0] score_ff;
   logic          last_ff;

   always_comb begin
      prod  = 20'(ratio_ff) * 20'(s2_lo_ff);
      limit = prod[19:8];
      if (mode_ff == ped_pkg::MODE_BINARY) begin
         score_in = PW'((s2_lo_ff >= min_dif_ff) && (12'(s2_lat_ff) <= limit));
      end else begin
         score_in = (s2_lo_ff > s2_lat_ff) ? s2_lo_ff - s2_lat_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         score_ff <= score_in;
         last_ff  <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = score_ff;
   assign rsp_tlast  = last_ff;

   // ---------------------------------------------------------- assertions
   a_fill_range : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("row count beyond memory depth");

   a_wp_range : assert property (@(posedge clock) disable iff (reset)
      32'(wp_ff) < DEPTH)
      else $error("write pointer beyond memory depth");

   a_fire_enters : assert property (@(posedge clock) disable iff (reset)
      (accept && fire) |=> s1_v_ff)
      else $error("firing pixel did not enter the pipeline");

   a_binary_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && mode_ff == ped_pkg::MODE_BINARY) |-> (rsp_tdata[7:1] == '0))
      else $error("binary mode result wider than a flag");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: plate edge point detector bench
// Streams pixel rows through the detector under random back-pressure, predicts
// every score word from the row history and the register settings, and checks
// each returned word in order. Directed rows come first, then random phases
// with fresh register settings.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_OFF    = ped_pkg::DEFAULT_MAX_OFFSET;
   localparam int ROW_DEPTH  = 2 * MAX_OFF;
   localparam int MAX_IDLE   = 12;
   localparam int DRAIN_WAIT = 8;   // three pipeline stages plus margin

   // one expected result word
   typedef struct {
      logic [7:0] score;
      logic       row_end;
   } score_word_type;

   // -------------------------------------------------------------------------
   // Scoreboard: row history and register copy, expected score words in order
   // -------------------------------------------------------------------------
   class edge_score_board_type;
      logic [7:0]  row_pixels [ROW_DEPTH];   // newest first
      int unsigned row_seen;
      logic        mode;
      logic [5:0]  offset;
      logic [7:0]  min_dif;
      logic [11:0] ratio;
      score_word_type expected_q [$];
      int unsigned pixels_taken;
      int unsigned scores_checked;
      int unsigned row_ends;
      int unsigned plate_hits;
      int unsigned mismatches;
      int unsigned failures;

      function new();
         foreach (row_pixels[i]) row_pixels[i] = '0;
         row_seen       = 0;
         mode           = ped_pkg::MODE_SCORE;
         offset         = ped_pkg::RST_OFFSET;
         min_dif        = ped_pkg::RST_MIN_DIF;
         ratio          = ped_pkg::RST_RATIO;
         pixels_taken   = 0;
         scores_checked = 0;
         row_ends       = 0;
         plate_hits     = 0;
         mismatches     = 0;
         failures       = 0;
      endfunction

      function void write_reg(ped_pkg::csr_index_type idx, logic [11:0] val);
         case (idx)
            ped_pkg::CSR_MODE:    mode    = val[0];
            ped_pkg::CSR_OFFSET:  offset  = val[5:0];
            ped_pkg::CSR_MIN_DIF: min_dif = val[7:0];
            ped_pkg::CSR_RATIO:   ratio   = val[11:0];
            default: ;
         endcase
      endfunction

      // offset as the block uses it: zero acts as one, clamp at the maximum
      function int unsigned span();
         if (offset == 0) return 1;
         if (offset > MAX_OFF) return MAX_OFF;
         return offset;
      endfunction

      // note one accepted pixel and predict the score word it makes, if any
      function void take_pixel(logic [7:0] px, logic row_first, logic row_last);
         int unsigned s, l, c, r, dl, dr, lo, lat, limit;
         score_word_type w;
         s = span();
         pixels_taken++;
         if (row_first) row_seen = 0;
         if (row_seen >= 2 * s) begin
            l   = row_pixels[2 * s - 1];
            c   = row_pixels[s - 1];
            r   = px;
            dl  = (l > c) ? l - c : 0;
            dr  = (r > c) ? r - c : 0;
            lo  = (dl < dr) ? dl : dr;
            lat = (l > r) ? l - r : r - l;
            if (mode == ped_pkg::MODE_SCORE) begin
               w.score = (lo > lat) ? 8'(lo - lat) : 8'd0;
            end else begin
               limit   = (ratio * lo) >> 8;
               w.score = (lo >= min_dif && lat <= limit) ? 8'd1 : 8'd0;
               if (w.score == 8'd1) plate_hits++;
            end
            w.row_end = row_last;
            expected_q = {expected_q, w};
         end
         for (int i = ROW_DEPTH - 1; i > 0; i--) row_pixels[i] = row_pixels[i - 1];
         row_pixels[0] = px;
         if (row_last) row_seen = 0;
         else if (row_seen < ROW_DEPTH) row_seen++;
      endfunction

      // compare a returned word with the oldest expectation
      function void check_score(logic [7:0] score, logic row_end);
         score_word_type w;
         if (expected_q.size() == 0) begin
            failures++;
            $display("unexpected score word %0d (row_end %0d) with nothing pending",
                     score, row_end);
            return;
         end
         w = expected_q.pop_front();
         scores_checked++;
         if (row_end) row_ends++;
         if (score !== w.score || row_end !== w.row_end) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display("score word %0d: expected score %0d row_end %0d, got score %0d row_end %0d",
                        scores_checked, w.score, w.row_end, score, row_end);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block signals; every input known from time zero
   // -------------------------------------------------------------------------
   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata  = '0;    // [7:0] pixel
   logic                           req_tuser  = 1'b0;  // [0] first_in_row
   logic                           req_tlast  = 1'b0;  // last_in_row
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [7:0]                     rsp_tdata;          // [7:0] score
   logic                           rsp_tlast;          // row_end
   logic                           csr_we     = 1'b0;
   logic [ped_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [ped_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   bit tx_calm = 1'b0;   // sender runs without gaps while set
   bit rx_calm = 1'b0;   // receiver runs without stalls while set
   int unsigned settings_used = 0;

   edge_score_board_type sb = new();

   initial begin
      forever #5 clock = ~clock;
   end

   plate_edge_point_detector #(
      .MAX_OFFSET(MAX_OFF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Watch both streams at the clock edge; values seen here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.take_pixel(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_score(rsp_tdata, rsp_tlast);
      end
   end

   // Receiver: draw a stall before every word, switch to a calm stretch now and then.
   initial begin
      int unsigned stall;
      int unsigned words;
      words = 0;
      while (reset) @(posedge clock);
      forever begin
         stall = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         words++;
         if (words % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // -------------------------------------------------------------------------
   // Driving tasks
   // -------------------------------------------------------------------------

   // Offer one pixel word after a random gap; hold it until it is taken.
   // Valid stays high between back-to-back words.
   task automatic send_pixel(logic [7:0] px, logic row_first, logic row_last);
      int unsigned gap;
      gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= row_first;
      req_tlast  <= row_last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_one(ped_pkg::csr_index_type idx, logic [11:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // Write all four registers on consecutive edges; only while the stream is idle.
   task automatic write_settings(logic md, logic [5:0] off, logic [7:0] mdif,
                                 logic [11:0] rat);
      write_one(ped_pkg::CSR_MODE, 12'(md));
      write_one(ped_pkg::CSR_OFFSET, 12'(off));
      write_one(ped_pkg::CSR_MIN_DIF, 12'(mdif));
      write_one(ped_pkg::CSR_RATIO, rat);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Drop valid, wait for every expected word, then let the pipeline empty
   // of pixels that make no word.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // One row of pixels. Shaped rows alternate bright and dark bands of one
   // offset width, so centres sit in dips that can pass the binary test.
   // restart_at places a stray first-of-row mark inside the row.
   task automatic send_row(int unsigned len, int unsigned span, bit shaped,
                           bit keep_first, bit keep_last, int unsigned restart_at);
      int unsigned hi, lo;
      logic [7:0]  px;
      hi = $urandom_range(60, 255);
      lo = $urandom_range(0, hi - 40);
      for (int unsigned i = 0; i < len; i++) begin
         if (shaped && $urandom_range(0, 9) != 0)
            px = ((i / span) % 2 == 1) ? 8'(lo + $urandom_range(0, 8))
                                       : 8'(hi - $urandom_range(0, 8));
         else
            px = 8'($urandom_range(0, 255));
         send_pixel(px, (i == 0 && keep_first) || (i == restart_at),
                    (i == len - 1) && keep_last);
      end
   endtask

   // One random phase: new settings, then rows until the budget is spent.
   task automatic run_phase(int unsigned k, int unsigned budget);
      logic [5:0]  off;
      logic [7:0]  mdif;
      logic [11:0] rat;
      int unsigned sent, len, span, kind;
      case (k % 6)
         0: off = 6'd1;
         1: off = 6'd2;
         2: off = 6'd32;
         3: off = 6'd63;   // above the maximum, clamps
         4: off = 6'd0;    // zero acts as one
         default: off = 6'($urandom_range(1, 8));
      endcase
      case (k % 4)
         0: mdif = 8'd0;
         1: mdif = 8'd255;
         default: mdif = 8'($urandom_range(0, 60));
      endcase
      case (k % 3)
         0: rat = 12'd0;
         1: rat = 12'd4095;
         default: rat = 12'($urandom_range(0, 600));
      endcase
      write_settings(logic'(k % 2), off, mdif, rat);
      span = sb.span();
      tx_calm = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < budget) begin
         len  = $urandom_range(1, 4 * span + 3);
         kind = $urandom_range(0, 9);
         // mostly well-formed rows; a few lose a mark or gain a stray restart
         case (kind)
            0: send_row(len, span, 1'b1, 1'b0, 1'b1, len);
            1: send_row(len, span, 1'b1, 1'b1, 1'b0, len);
            2: send_row(len, span, 1'b1, 1'b1, 1'b1, $urandom_range(1, len));
            3: send_row(len, span, 1'b0, 1'b1, 1'b1, len);
            default: send_row(len, span, 1'b1, 1'b1, 1'b1, len);
         endcase
         sent += len;
         if ($urandom_range(0, 3) == 0) tx_calm = !tx_calm;
      end
      // leave a row open now and then so the next settings land mid-row
      if ($urandom_range(0, 1) == 0) send_row(span + 1, span, 1'b1, 1'b1, 1'b0, span + 1);
      drain();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: offset four, score mode; one centre at the ninth pixel
      send_pixel(8'd255, 1'b1, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd128, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b0, 1'b1);
      drain();

      // offset zero, score mode: full swing, a longer row, a short row,
      // then a row with no start mark and a restart inside it
      write_settings(ped_pkg::MODE_SCORE, 6'd0, 8'd20, 12'd128);
      send_pixel(8'd255, 1'b1, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b0, 1'b1);
      send_pixel(8'd200, 1'b1, 1'b0);
      send_pixel(8'd10, 1'b0, 1'b0);
      send_pixel(8'd190, 1'b0, 1'b0);
      send_pixel(8'd5, 1'b0, 1'b0);
      send_pixel(8'd255, 1'b0, 1'b1);
      send_pixel(8'd7, 1'b1, 1'b0);
      send_pixel(8'd9, 1'b0, 1'b1);
      send_pixel(8'd50, 1'b0, 1'b0);
      send_pixel(8'd60, 1'b0, 1'b0);
      send_pixel(8'd80, 1'b1, 1'b0);
      send_pixel(8'd90, 1'b0, 1'b0);
      send_pixel(8'd100, 1'b0, 1'b1);
      drain();

      // binary mode with the loosest limits: a flat row still counts
      write_settings(ped_pkg::MODE_BINARY, 6'd1, 8'd0, 12'd4095);
      send_pixel(8'd0, 1'b1, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b0);
      send_pixel(8'd0, 1'b0, 1'b1);
      drain();

      for (int unsigned k = 0; k < 12; k++) run_phase(k, 55);

      drain();
      if (sb.pending() != 0) begin
         sb.failures++;
         $display("%0d score words never arrived", sb.pending());
      end
      $display("Ran %0d pixels under %0d register settings; %0d score words checked,",
               sb.pixels_taken, settings_used, sb.scores_checked);
      $display("%0d of them row ends, %0d plate points flagged, %0d mismatches.",
               sb.row_ends, sb.plate_hits, sb.mismatches);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
